// File: rtl/eakc_pkg.sv
// ----------------------------------------------------------------------------
// eakc_pkg
// shared constants and types for the aged key cache
// ----------------------------------------------------------------------------
package eakc_pkg;

  localparam int DEF_CAPACITY = 1024;
  localparam int DEF_AGE_BITS = 32;
  localparam int KEY_W        = 96;
  localparam int REG_W        = 11;
  localparam int SLOT_W       = 10;
  localparam int IDX_W        = 2;

  localparam logic [IDX_W-1:0] REG_MAX_ENTRIES  = 2'd0;
  localparam logic [IDX_W-1:0] REG_PRUNE_START  = 2'd1;
  localparam logic [IDX_W-1:0] REG_PRUNE_TARGET = 2'd2;

  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_PRUNE  = 1'b1;

  localparam logic [REG_W-1:0] RST_MAX_ENTRIES  = 11'd1024;
  localparam logic [REG_W-1:0] RST_PRUNE_START  = 11'd512;
  localparam logic [REG_W-1:0] RST_PRUNE_TARGET = 11'd341;

endpackage

// File: rtl/eakc_mem.sv
// ----------------------------------------------------------------------------
// eakc_mem
// slot table memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module eakc_mem #(
  parameter int DEPTH  = 1024,
  parameter int WIDTH  = 129
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/epoch_aged_key_cache_top.sv
// ----------------------------------------------------------------------------
// epoch_aged_key_cache_top
// keyed slot table with epoch age stamps, lookup with allocate and prune
// ----------------------------------------------------------------------------
// One item at a time. After reset a clearing pass writes every slot invalid;
// no item is taken during it. A lookup sweeps the slot memory one slot per
// cycle through its single read port: a hit ends the sweep at the matching
// slot, a miss reads every slot. A prune removes nothing when the count is
// below prune_start, else it runs one find-oldest pass and one remove pass
// per removed age group until the count is at most prune_target or no older
// age group is left. The result sits in an output register, so the next
// item is taken while it waits.
module epoch_aged_key_cache_top
  import eakc_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int AGE_BITS = DEF_AGE_BITS
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [REG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    req_type,
  input  logic signed [31:0]      key_x,
  input  logic signed [31:0]      key_y,
  input  logic signed [31:0]      key_z,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    hit,
  output logic                    present,
  output logic [SLOT_W-1:0]       slot,
  output logic [REG_W-1:0]        removed_count,
  output logic [REG_W-1:0]        entry_count
);

  localparam int IW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > REG_W) ? CW : REG_W;
  localparam int MW   = 1 + AGE_BITS + KEY_W;
  localparam logic [IW-1:0] LAST = IW'(CAPACITY - 1);
  localparam logic [AGE_BITS-1:0] AGE_TOP = '1;

  typedef enum logic [7:0] {
    S_CLR  = 8'b0000_0001,
    S_IDLE = 8'b0000_0010,
    S_LK   = 8'b0000_0100,
    S_PCHK = 8'b0000_1000,
    S_PLP  = 8'b0001_0000,
    S_PMIN = 8'b0010_0000,
    S_PDEL = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_t;

  state_t state;

  logic [REG_W-1:0]    max_entries, prune_start, prune_target;
  logic [AGE_BITS-1:0] epoch;
  logic [CW-1:0]       count;
  logic [KEY_W-1:0]    req_key;
  logic [IW-1:0]       idx, ra, free_slot;
  logic                iss_on, rv, have_free, any;
  logic [AGE_BITS-1:0] min_age;
  logic                res_hit, res_present;
  logic [IW-1:0]       res_slot;
  logic [CW-1:0]       res_removed;

  logic                rd_en, wr_en;
  logic [IW-1:0]       wr_addr;
  logic [MW-1:0]       rd_data, wr_data;
  logic                d_valid;
  logic [AGE_BITS-1:0] d_age;
  logic [KEY_W-1:0]    d_key;
  logic                key_eq, free_now, room, cand_any;
  logic [IW-1:0]       fslot;
  logic [AGE_BITS-1:0] cand_min;

  assign d_valid = rd_data[MW-1];
  assign d_age   = rd_data[MW-2 -: AGE_BITS];
  assign d_key   = rd_data[KEY_W-1:0];
  assign key_eq  = d_valid && (d_key == req_key);
  assign free_now = have_free || !d_valid;
  assign fslot    = have_free ? free_slot : ra;
  assign room     = CMPW'(count) < CMPW'(max_entries);
  assign cand_any = any || d_valid;
  assign cand_min = (d_valid && (!any || d_age < min_age)) ? d_age : min_age;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  eakc_mem #(.DEPTH(CAPACITY), .WIDTH(MW)) u_mem (
    .clk(clk), .rd_en(rd_en), .rd_addr(idx), .rd_data(rd_data),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
  );

  always_comb begin
    rd_en   = iss_on && (state == S_LK || state == S_PMIN || state == S_PDEL);
    wr_en   = 1'b0;
    wr_addr = idx;
    wr_data = '0;
    case (state)
      S_CLR: begin
        wr_en = 1'b1;
      end
      S_LK: begin
        if (rv && ra == LAST && !key_eq && free_now && room) begin
          wr_en   = 1'b1;
          wr_addr = fslot;
          wr_data = {1'b1, epoch, req_key};
        end
      end
      S_PDEL: begin
        if (rv && d_valid && d_age == min_age) begin
          wr_en   = 1'b1;
          wr_addr = ra;
          wr_data = {1'b0, rd_data[MW-2:0]};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLR;
      max_entries  <= RST_MAX_ENTRIES;
      prune_start  <= RST_PRUNE_START;
      prune_target <= RST_PRUNE_TARGET;
      epoch        <= '0;
      count        <= '0;
      idx          <= '0;
      iss_on       <= 1'b0;
      rv           <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_MAX_ENTRIES:  max_entries  <= cfg_data;
          REG_PRUNE_START:  prune_start  <= cfg_data;
          REG_PRUNE_TARGET: prune_target <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      rv <= rd_en;
      ra <= idx;
      if (rd_en) begin
        idx <= idx + 1'b1;
        if (idx == LAST) begin
          iss_on <= 1'b0;
        end
      end
      case (state)
        S_CLR: begin
          idx <= idx + 1'b1;
          if (idx == LAST) begin
            idx   <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            req_key     <= {key_z, key_y, key_x};
            res_hit     <= 1'b0;
            res_present <= 1'b0;
            res_slot    <= '0;
            res_removed <= '0;
            have_free   <= 1'b0;
            idx         <= '0;
            if (req_type == REQ_PRUNE) begin
              if (epoch != AGE_TOP) begin
                epoch <= epoch + 1'b1;
              end
              state <= S_PCHK;
            end else begin
              iss_on <= 1'b1;
              state  <= S_LK;
            end
          end
        end
        S_LK: begin
          if (rv) begin
            if (key_eq) begin
              res_hit     <= 1'b1;
              res_present <= 1'b1;
              res_slot    <= ra;
              iss_on      <= 1'b0;
              rv          <= 1'b0;
              state       <= S_FIN;
            end else begin
              if (!d_valid && !have_free) begin
                have_free <= 1'b1;
                free_slot <= ra;
              end
              if (ra == LAST) begin
                if (free_now && room) begin
                  res_present <= 1'b1;
                  res_slot    <= fslot;
                  count       <= count + 1'b1;
                end
                state <= S_FIN;
              end
            end
          end
        end
        S_PCHK: begin
          state <= (CMPW'(count) < CMPW'(prune_start)) ? S_FIN : S_PLP;
        end
        S_PLP: begin
          if (CMPW'(count) > CMPW'(prune_target)) begin
            idx    <= '0;
            iss_on <= 1'b1;
            any    <= 1'b0;
            state  <= S_PMIN;
          end else begin
            state <= S_FIN;
          end
        end
        S_PMIN: begin
          if (rv) begin
            any     <= cand_any;
            min_age <= cand_min;
            if (ra == LAST) begin
              if (!cand_any || cand_min == epoch) begin
                state <= S_FIN;
              end else begin
                idx    <= '0;
                iss_on <= 1'b1;
                state  <= S_PDEL;
              end
            end
          end
        end
        S_PDEL: begin
          if (wr_en) begin
            count       <= count - 1'b1;
            res_removed <= res_removed + 1'b1;
          end
          if (rv && ra == LAST) begin
            state <= S_PLP;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid     <= 1'b1;
            hit           <= res_hit;
            present       <= res_present;
            slot          <= SLOT_W'(res_slot);
            removed_count <= REG_W'(res_removed);
            entry_count   <= REG_W'(count);
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    CMPW'(count) <= CMPW'(CAPACITY))
    else $error("entry count above capacity");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !wr_en)
    else $error("memory written while idle");

  a_hit_present: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> present && removed_count == '0)
    else $error("hit without present");

  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second item taken during work");

endmodule
